// ----- sv/adaptive_bilateral_filter_defines.svh -----
// Assertion macros for the adaptive bilateral filter checker.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ADAPTIVE_BILATERAL_FILTER_DEFINES_SVH
`define ADAPTIVE_BILATERAL_FILTER_DEFINES_SVH

// same-cycle implication
`define ABF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ABF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/abf_pkg.sv -----
// Shared constants, exp tables and the elaboration-time exp helper.
// No dependencies; used by abf_lane, abf_merge and the top level.
package abf_pkg;

  localparam int unsigned WINDOW_DEF = 7;
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned CLS_W      = 12;
  localparam int unsigned COL_ROWS   = 7;
  localparam int unsigned COL_CENTER = 3;

  localparam int unsigned LC_LIM     = 960;
  localparam int unsigned SIG_X1     = 240;
  localparam int unsigned SIG_X2     = 480;
  localparam int unsigned SIG_BASE1  = 1792;
  localparam int unsigned SIG_BASE2  = 7424;
  localparam int unsigned SIG_FLOOR  = 1280;
  localparam int unsigned RECIP3     = 43691;  // (2^17+1)/3
  localparam int unsigned RECIP5     = 52429;  // (2^18+1)/5
  localparam int unsigned ARG_LIMIT  = 3072;
  localparam int unsigned SPACE_SCL  = 8;
  localparam int unsigned WQ_W       = 17;     // Q16 weight incl. 1.0

  localparam int unsigned S_W  = 13;
  localparam int unsigned S2_W = 25;
  localparam int unsigned LC_W = 11;
  localparam int unsigned Q_W  = 12;

  localparam logic [WQ_W-1:0] EXP_INT [16] = '{
    17'd65536, 17'd24109, 17'd8869, 17'd3263, 17'd1200, 17'd442, 17'd162, 17'd60,
    17'd22, 17'd8, 17'd3, 17'd1, 17'd0, 17'd0, 17'd0, 17'd0
  };
  localparam logic [WQ_W-1:0] EXP_SIXT [16] = '{
    17'd65536, 17'd61565, 17'd57835, 17'd54331, 17'd51039, 17'd47947, 17'd45042,
    17'd42313, 17'd39750, 17'd37341, 17'd35079, 17'd32954, 17'd30957, 17'd29081,
    17'd27319, 17'd25664
  };
  localparam logic [WQ_W-1:0] EXP_FINE [16] = '{
    17'd65536, 17'd65280, 17'd65026, 17'd64772, 17'd64520, 17'd64268, 17'd64018,
    17'd63768, 17'd63520, 17'd63272, 17'd63025, 17'd62780, 17'd62535, 17'd62291,
    17'd62048, 17'd61806
  };

  // Q16 exp(-t/256); called with constant arguments only
  function automatic logic [WQ_W-1:0] exp_q16(input logic [31:0] t);
    logic [63:0] p;
    p = 64'd0;
    if (t < 32'(ARG_LIMIT)) begin
      p = 64'(EXP_INT[t[11:8]]) * 64'(EXP_SIXT[t[7:4]]);
      p = p * 64'(EXP_FINE[t[3:0]]);
      p = p + 64'h8000_0000;
    end
    return p[48:32];
  endfunction

endpackage

// ----- sv/abf_lane.sv -----
// One window row: range argument by restoring division, exp lookups, tap
// weight and the row's weighted sums. Depends on abf_pkg.
module abf_lane #(
  parameter int unsigned WINDOW = abf_pkg::WINDOW_DEF,
  parameter int unsigned ROW    = 0
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       start,
  input  logic [WINDOW-1:0][abf_pkg::PIX_W-1:0]      row_pix,
  input  logic [abf_pkg::PIX_W-1:0]                  i0,
  input  logic signed [abf_pkg::LC_W-1:0]            lc,
  input  logic [abf_pkg::S2_W-1:0]                   s2,
  output logic                                       done,
  output logic [$clog2(WINDOW*65536*255+1)-1:0]      num,
  output logic [$clog2(WINDOW*65536+1)-1:0]          den
);

  localparam int unsigned LN_W = $clog2(WINDOW*65536*255+1);
  localparam int unsigned LD_W = $clog2(WINDOW*65536+1);
  localparam int unsigned CW   = $clog2(WINDOW);
  localparam int HALF = int'(WINDOW / 2);
  localparam int DY   = int'(ROW) - HALF;
  localparam int unsigned WQ = abf_pkg::WQ_W;

  localparam logic [2:0] L_IDLE = 3'd0;
  localparam logic [2:0] L_SQ   = 3'd1;
  localparam logic [2:0] L_NUM  = 3'd2;
  localparam logic [2:0] L_DIV  = 3'd3;
  localparam logic [2:0] L_E1   = 3'd4;
  localparam logic [2:0] L_E2   = 3'd5;
  localparam logic [2:0] L_W    = 3'd6;
  localparam logic [2:0] L_ACC  = 3'd7;

  logic [WQ-1:0] sw [WINDOW];

  for (genvar c = 0; c < WINDOW; c++) begin : g_sw
    localparam int DX = c - HALF;
    localparam logic [WQ-1:0] SWC =
      abf_pkg::exp_q16(32'(abf_pkg::SPACE_SCL * (DX*DX + DY*DY)));
    assign sw[c] = SWC;
  end

  logic [2:0]                    state_r, state_nxt;
  logic [CW-1:0]                 col_r, col_nxt;
  logic [abf_pkg::PIX_W-1:0]     i1_r, i1_nxt;
  logic [27:0]                   ad2_r, ad2_nxt;
  logic [36:0]                   rem_r, rem_nxt;
  logic [35:0]                   dv_r, dv_nxt;
  logic [abf_pkg::Q_W-1:0]       q_r, q_nxt;
  logic [3:0]                    k_r, k_nxt;
  logic                          zero_r, zero_nxt;
  logic [33:0]                   p1_r, p1_nxt;
  logic [WQ-1:0]                 e_r, e_nxt;
  logic [WQ-1:0]                 w_r, w_nxt;
  logic [LN_W-1:0]               num_r, num_nxt;
  logic [LD_W-1:0]               den_r, den_nxt;
  logic                          done_r, done_nxt;

  logic [abf_pkg::PIX_W-1:0] i1;
  logic signed [15:0]        d;
  logic [13:0]               ad;
  logic [40:0]               n_full;
  logic [37:0]               lim;
  logic                      ge;
  logic [50:0]               p2s;
  logic [33:0]               pw;

  always_comb begin
    i1     = row_pix[col_r];
    d      = $signed({3'b000, i0, 5'b00000}) - $signed({3'b000, i1, 5'b00000})
             - $signed({{5{lc[abf_pkg::LC_W-1]}}, lc});
    ad     = d[15] ? 14'(-d) : d[13:0];
    n_full = {ad2_r, 13'b0} + 41'(s2 >> 1);
    lim    = {2'b00, s2, 11'b0} + {3'b000, s2, 10'b0};
    ge     = rem_r >= 37'(dv_r);
    p2s    = 51'(p1_r) * 51'(abf_pkg::EXP_FINE[q_r[3:0]]) + 51'(32'h8000_0000);
    pw     = 34'(sw[col_r]) * 34'(e_r) + 34'd32768;

    state_nxt = state_r;
    col_nxt   = col_r;
    i1_nxt    = i1_r;
    ad2_nxt   = ad2_r;
    rem_nxt   = rem_r;
    dv_nxt    = dv_r;
    q_nxt     = q_r;
    k_nxt     = k_r;
    zero_nxt  = zero_r;
    p1_nxt    = p1_r;
    e_nxt     = e_r;
    w_nxt     = w_r;
    num_nxt   = num_r;
    den_nxt   = den_r;
    done_nxt  = done_r;

    case (state_r)
      L_IDLE: begin
        if (start) begin
          num_nxt   = '0;
          den_nxt   = '0;
          col_nxt   = '0;
          done_nxt  = 1'b0;
          state_nxt = L_SQ;
        end
      end
      L_SQ: begin
        i1_nxt    = i1;
        ad2_nxt   = 28'(ad) * 28'(ad);
        state_nxt = L_NUM;
      end
      L_NUM: begin
        q_nxt = '0;
        // out-of-range argument: exp is zero, skip the divide
        if (n_full >= 41'(lim)) begin
          zero_nxt  = 1'b1;
          state_nxt = L_E1;
        end else begin
          zero_nxt  = 1'b0;
          rem_nxt   = n_full[36:0];
          dv_nxt    = {s2, 11'b0};
          k_nxt     = 4'd11;
          state_nxt = L_DIV;
        end
      end
      L_DIV: begin
        if (ge) begin
          rem_nxt = rem_r - 37'(dv_r);
        end
        q_nxt  = {q_r[abf_pkg::Q_W-2:0], ge};
        dv_nxt = dv_r >> 1;
        k_nxt  = k_r - 4'd1;
        if (k_r == 4'd0) begin
          state_nxt = L_E1;
        end
      end
      L_E1: begin
        p1_nxt    = 34'(abf_pkg::EXP_INT[q_r[11:8]]) * 34'(abf_pkg::EXP_SIXT[q_r[7:4]]);
        state_nxt = L_E2;
      end
      L_E2: begin
        e_nxt     = zero_r ? '0 : p2s[48:32];
        state_nxt = L_W;
      end
      L_W: begin
        w_nxt     = pw[32:16];
        state_nxt = L_ACC;
      end
      L_ACC: begin
        num_nxt = num_r + LN_W'(25'(w_r) * 25'(i1_r));
        den_nxt = den_r + LD_W'(w_r);
        if (col_r == CW'(WINDOW - 1)) begin
          done_nxt  = 1'b1;
          state_nxt = L_IDLE;
        end else begin
          col_nxt   = col_r + 1'b1;
          state_nxt = L_SQ;
        end
      end
      default: state_nxt = L_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    col_r  <= col_nxt;
    i1_r   <= i1_nxt;
    ad2_r  <= ad2_nxt;
    rem_r  <= rem_nxt;
    dv_r   <= dv_nxt;
    q_r    <= q_nxt;
    k_r    <= k_nxt;
    zero_r <= zero_nxt;
    p1_r   <= p1_nxt;
    e_r    <= e_nxt;
    w_r    <= w_nxt;
    num_r  <= num_nxt;
    den_r  <= den_nxt;
  end

  assign done = done_r;
  assign num  = num_r;
  assign den  = den_r;

endmodule

// ----- sv/abf_merge.sv -----
// Merging stage: sums the lane totals and forms the rounded, saturated
// quotient with an 8-step restoring divider. Depends on abf_pkg.
module abf_merge #(
  parameter int unsigned WINDOW = abf_pkg::WINDOW_DEF
) (
  input  logic                                                 clk,
  input  logic                                                 rst_n,
  input  logic                                                 start,
  input  logic [WINDOW-1:0][$clog2(WINDOW*65536*255+1)-1:0]    lane_num,
  input  logic [WINDOW-1:0][$clog2(WINDOW*65536+1)-1:0]        lane_den,
  input  logic [abf_pkg::PIX_W-1:0]                            i0,
  output logic                                                 done,
  output logic [abf_pkg::PIX_W-1:0]                            res
);

  localparam int unsigned LN_W = $clog2(WINDOW*65536*255+1);
  localparam int unsigned LD_W = $clog2(WINDOW*65536+1);
  localparam int unsigned TD_W = $clog2(WINDOW*WINDOW*65536+1);
  localparam int unsigned RW   = TD_W + 9;

  localparam logic [1:0] M_IDLE = 2'd0;
  localparam logic [1:0] M_CHK  = 2'd1;
  localparam logic [1:0] M_DIV  = 2'd2;

  logic [1:0]                state_r, state_nxt;
  logic [RW-1:0]             tn_r, tn_nxt;
  logic [TD_W-1:0]           td_r, td_nxt;
  logic [RW-1:0]             rem_r, rem_nxt;
  logic [RW-1:0]             dv_r, dv_nxt;
  logic [abf_pkg::PIX_W-1:0] q_r, q_nxt;
  logic [2:0]                k_r, k_nxt;
  logic                      done_r, done_nxt;
  logic [abf_pkg::PIX_W-1:0] res_r, res_nxt;

  logic [RW-1:0]   sum_n;
  logic [TD_W-1:0] sum_d;
  logic [RW-1:0]   nn;
  logic            ge;

  always_comb begin
    sum_n = '0;
    sum_d = '0;
    for (int i = 0; i < int'(WINDOW); i++) begin
      sum_n = sum_n + RW'(lane_num[i]);
      sum_d = sum_d + TD_W'(lane_den[i]);
    end
    nn = tn_r + RW'(td_r >> 1);
    ge = rem_r >= dv_r;

    state_nxt = state_r;
    tn_nxt    = tn_r;
    td_nxt    = td_r;
    rem_nxt   = rem_r;
    dv_nxt    = dv_r;
    q_nxt     = q_r;
    k_nxt     = k_r;
    done_nxt  = 1'b0;
    res_nxt   = res_r;

    case (state_r)
      M_IDLE: begin
        if (start) begin
          tn_nxt    = sum_n;
          td_nxt    = sum_d;
          state_nxt = M_CHK;
        end
      end
      M_CHK: begin
        if (td_r == '0) begin
          // every weight vanished: pass the center pixel
          res_nxt   = i0;
          done_nxt  = 1'b1;
          state_nxt = M_IDLE;
        end else if (nn >= RW'({td_r, 8'b0})) begin
          res_nxt   = '1;
          done_nxt  = 1'b1;
          state_nxt = M_IDLE;
        end else begin
          rem_nxt   = nn;
          dv_nxt    = RW'({td_r, 7'b0});
          q_nxt     = '0;
          k_nxt     = 3'd7;
          state_nxt = M_DIV;
        end
      end
      M_DIV: begin
        if (ge) begin
          rem_nxt = rem_r - dv_r;
        end
        q_nxt  = {q_r[abf_pkg::PIX_W-2:0], ge};
        dv_nxt = dv_r >> 1;
        k_nxt  = k_r - 3'd1;
        if (k_r == 3'd0) begin
          res_nxt   = {q_r[abf_pkg::PIX_W-2:0], ge};
          done_nxt  = 1'b1;
          state_nxt = M_IDLE;
        end
      end
      default: state_nxt = M_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    tn_r  <= tn_nxt;
    td_r  <= td_nxt;
    rem_r <= rem_nxt;
    dv_r  <= dv_nxt;
    q_r   <= q_nxt;
    k_r   <= k_nxt;
    res_r <= res_nxt;
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

// ----- sv/adaptive_bilateral_filter.sv -----
// Channel  Ports                               Word
// in       in_valid / in_stall                 7 column pixels, LoG class, row start
// out      out_valid / out_stall               filtered center pixel
//
// One item at a time. A column that does not fill the window is taken while idle.
// Otherwise sigma and its square are registered, then the lanes run their per-tap
// restoring divider (skipped for an out-of-table range argument), then the merge.
// The output register frees the input: a new word is taken while a result waits.
// rst_n is synchronous; it clears control, the window and the class delay.
// Top level; depends on abf_pkg, abf_lane and abf_merge.
module adaptive_bilateral_filter #(
  parameter int unsigned WINDOW = abf_pkg::WINDOW_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [abf_pkg::PIX_W-1:0]         in_pix_row0,
  input  logic [abf_pkg::PIX_W-1:0]         in_pix_row1,
  input  logic [abf_pkg::PIX_W-1:0]         in_pix_row2,
  input  logic [abf_pkg::PIX_W-1:0]         in_pix_row3,
  input  logic [abf_pkg::PIX_W-1:0]         in_pix_row4,
  input  logic [abf_pkg::PIX_W-1:0]         in_pix_row5,
  input  logic [abf_pkg::PIX_W-1:0]         in_pix_row6,
  input  logic signed [abf_pkg::CLS_W-1:0]  in_log_class,
  input  logic                              in_row_start,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [abf_pkg::PIX_W-1:0]         out_filtered_pixel
);

  localparam int unsigned HALF = WINDOW / 2;
  localparam int unsigned CW   = $clog2(WINDOW);
  localparam int unsigned LN_W = $clog2(WINDOW*65536*255+1);
  localparam int unsigned LD_W = $clog2(WINDOW*65536+1);
  localparam int unsigned PW   = abf_pkg::PIX_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SIG   = 3'd1;
  localparam logic [2:0] ST_SQR   = 3'd2;
  localparam logic [2:0] ST_LSTRT = 3'd3;
  localparam logic [2:0] ST_LWAIT = 3'd4;
  localparam logic [2:0] ST_MWAIT = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  logic [PW-1:0] col_pix [abf_pkg::COL_ROWS];

  assign col_pix[0] = in_pix_row0;
  assign col_pix[1] = in_pix_row1;
  assign col_pix[2] = in_pix_row2;
  assign col_pix[3] = in_pix_row3;
  assign col_pix[4] = in_pix_row4;
  assign col_pix[5] = in_pix_row5;
  assign col_pix[6] = in_pix_row6;

  logic [WINDOW-1:0][WINDOW-1:0][PW-1:0] win_r, win_nxt;
  logic signed [abf_pkg::CLS_W-1:0]      dly_r [HALF+1];
  logic [CW-1:0]                         cnt_r, cnt_nxt;
  logic [2:0]                            state_r, state_nxt;
  logic [abf_pkg::S_W-1:0]               s_r, s_nxt;
  logic [abf_pkg::S2_W-1:0]              s2_r;
  logic signed [abf_pkg::LC_W-1:0]       lc_r, lc_nxt;
  logic                                  out_valid_r, out_valid_nxt;
  logic [PW-1:0]                         out_pix_r, out_pix_nxt;

  logic [WINDOW-1:0]                     lane_done;
  logic [WINDOW-1:0][LN_W-1:0]           lane_num;
  logic [WINDOW-1:0][LD_W-1:0]           lane_den;
  logic                                  merge_start;
  logic                                  merge_done;
  logic [PW-1:0]                         merge_res;
  logic                                  accept;
  logic [CW-1:0]                         cnt0;
  logic [PW-1:0]                         i0;

  logic signed [abf_pkg::CLS_W-1:0] lcen;
  logic [abf_pkg::CLS_W-1:0]        x;
  logic [12:0]                      n3;
  logic [14:0]                      n5;
  logic [29:0]                      m3;
  logic [30:0]                      m5;

  assign accept = in_valid && !in_stall;
  assign i0     = win_r[HALF][HALF];

  // window rows take clamped source rows of the column
  for (genvar r = 0; r < WINDOW; r++) begin : g_row
    localparam int SRC_RAW = int'(abf_pkg::COL_CENTER) - int'(HALF) + r;
    localparam int SRC = SRC_RAW < 0 ? 0 :
                         (SRC_RAW > int'(abf_pkg::COL_ROWS) - 1 ?
                          int'(abf_pkg::COL_ROWS) - 1 : SRC_RAW);
    assign win_nxt[r] = accept ? {col_pix[SRC], win_r[r][WINDOW-1:1]} : win_r[r];

    abf_lane #(
      .WINDOW (WINDOW),
      .ROW    (r)
    ) u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .start   (state_r == ST_LSTRT),
      .row_pix (win_r[r]),
      .i0      (i0),
      .lc      (lc_r),
      .s2      (s2_r),
      .done    (lane_done[r]),
      .num     (lane_num[r]),
      .den     (lane_den[r])
    );
  end

  abf_merge #(
    .WINDOW (WINDOW)
  ) u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (merge_start),
    .lane_num (lane_num),
    .lane_den (lane_den),
    .i0       (i0),
    .done     (merge_done),
    .res      (merge_res)
  );

  always_comb begin
    lcen = dly_r[HALF];
    x    = lcen[abf_pkg::CLS_W-1] ? abf_pkg::CLS_W'(-lcen) : abf_pkg::CLS_W'(lcen);
    n3   = {x[7:0], 5'b00000} + 13'd1;
    n5   = {x[8:0], 6'b000000} + 15'd2;
    m3   = 30'(n3) * 30'(abf_pkg::RECIP3);
    m5   = 31'(n5) * 31'(abf_pkg::RECIP5);

    if (x <= abf_pkg::CLS_W'(abf_pkg::SIG_X1)) begin
      s_nxt = abf_pkg::S_W'(abf_pkg::SIG_BASE1) + abf_pkg::S_W'(m3 >> 17);
    end else if (x <= abf_pkg::CLS_W'(abf_pkg::SIG_X2)) begin
      s_nxt = abf_pkg::S_W'(abf_pkg::SIG_BASE2) - abf_pkg::S_W'(m5 >> 18);
    end else begin
      s_nxt = abf_pkg::S_W'(abf_pkg::SIG_FLOOR);
    end

    if (lcen < -$signed(abf_pkg::CLS_W'(abf_pkg::LC_LIM))) begin
      lc_nxt = -$signed(abf_pkg::LC_W'(abf_pkg::LC_LIM));
    end else if (lcen > $signed(abf_pkg::CLS_W'(abf_pkg::LC_LIM))) begin
      lc_nxt = $signed(abf_pkg::LC_W'(abf_pkg::LC_LIM));
    end else begin
      lc_nxt = lcen[abf_pkg::LC_W-1:0];
    end

    cnt0          = in_row_start ? '0 : cnt_r;
    cnt_nxt       = cnt_r;
    state_nxt     = state_r;
    merge_start   = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_pix_nxt   = out_pix_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (cnt0 < CW'(WINDOW - 1)) begin
            cnt_nxt = cnt0 + 1'b1;
          end else begin
            cnt_nxt   = cnt0;
            state_nxt = ST_SIG;
          end
        end
      end
      ST_SIG:   state_nxt = ST_SQR;
      ST_SQR:   state_nxt = ST_LSTRT;
      ST_LSTRT: state_nxt = ST_LWAIT;
      ST_LWAIT: begin
        if (&lane_done) begin
          merge_start = 1'b1;
          state_nxt   = ST_MWAIT;
        end
      end
      ST_MWAIT: begin
        if (merge_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_pix_nxt   = merge_res;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      win_r       <= '0;
      for (int i = 0; i <= int'(HALF); i++) begin
        dly_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      win_r       <= win_nxt;
      if (accept) begin
        for (int i = int'(HALF); i > 0; i--) begin
          dly_r[i] <= dly_r[i-1];
        end
        dly_r[0] <= in_log_class;
      end
    end
    if (state_r == ST_SIG) begin
      s_r  <= s_nxt;
      lc_r <= lc_nxt;
    end
    if (state_r == ST_SQR) begin
      s2_r <= abf_pkg::S2_W'(26'(s_r) * 26'(s_r));
    end
    out_pix_r <= out_pix_nxt;
  end

  assign in_stall           = (state_r != ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_filtered_pixel = out_pix_r;

endmodule

// ----- sv/abf_checker.sv -----
// Port-level checks for the adaptive bilateral filter, bound to the top level.
// Depends on adaptive_bilateral_filter_defines.svh.
`include "adaptive_bilateral_filter_defines.svh"

module abf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_filtered_pixel
);

  `ABF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_filtered_pixel), "stalled output word changed")
  `ABF_ASSERT_NOW(a_busy_before_out, $rose(out_valid), $past(in_stall), "result appeared without a busy phase")
  `ABF_ASSERT_NEXT(a_no_refill_idle, out_valid && !out_stall && !in_stall, !out_valid, "output refilled while idle")

endmodule

bind adaptive_bilateral_filter abf_checker u_abf_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_filtered_pixel (out_filtered_pixel)
);
